// ===== sv/region_decoded_byte_memory_assert.svh =====
// Assertion macros for the region-decoded byte memory.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef REGION_DECODED_BYTE_MEMORY_ASSERT_SVH
`define REGION_DECODED_BYTE_MEMORY_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define RDBM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only.
`define RDBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rdbm_pkg.sv =====
// Shared constants, types and helpers for the region-decoded byte memory.
// No dependencies; compile first.
package rdbm_pkg;

    localparam int unsigned FLASH_BYTES_DEF = 65536;
    localparam int unsigned RAM_BYTES_DEF   = 8192;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned SIZE_W = 2;

    // Region bases, held one bit wider so that span ends never wrap
    localparam logic [ADDR_W:0] RAM_BASE    = 33'h0_2000_0000;
    localparam logic [ADDR_W:0] PERIPH_BASE = 33'h0_3000_0000;
    localparam logic [ADDR_W:0] PERIPH_LEN  = 33'h0_0000_0008;

    // Access size codes
    localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

    // Access kind codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [1:0] region_t;
    localparam region_t REGION_NONE   = 2'd0;
    localparam region_t REGION_FLASH  = 2'd1;
    localparam region_t REGION_RAM    = 2'd2;
    localparam region_t REGION_PERIPH = 2'd3;

    typedef logic [2:0] len_t;

    // Number of bytes touched; the spare code behaves as a half word
    function automatic len_t access_len(input logic [SIZE_W-1:0] size);
        len_t n;
        case (size)
            SIZE_BYTE: n = 3'd1;
            SIZE_WORD: n = 3'd4;
            default:   n = 3'd2;
        endcase
        return n;
    endfunction

endpackage

// ===== sv/rdbm_if.sv =====
// Handshake channels of the region-decoded byte memory: access and result.
// Depends on rdbm_pkg.
interface rdbm_req_if;
    import rdbm_pkg::*;

    logic              valid;
    logic              ready;
    logic              enable;
    logic              op;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, enable, op, addr, size, write_data, input ready);
    modport sink   (input valid, enable, op, addr, size, write_data, output ready);
endinterface

interface rdbm_rsp_if;
    import rdbm_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              fault;

    modport source (output valid, read_data, fault, input ready);
    modport sink   (input valid, read_data, fault, output ready);
endinterface

// ===== sv/region_decoded_byte_memory.sv =====
// Top level of the region-decoded byte memory: decode, byte-banked stores, result stage.
// Depends on rdbm_pkg, rdbm_if and region_decoded_byte_memory_assert.svh.
`include "region_decoded_byte_memory_assert.svh"

// A bus target taking one access item per clock when not stalled. Flash sits at 0x00000000
// (FLASH_BYTES long), RAM at 0x20000000 (RAM_BYTES long), and a write-only
// window of two 32-bit registers at 0x30000000 (8 bytes). Accesses are byte,
// half word or word, little-endian, and may be unaligned. An access faults
// (read_data zero, nothing stored) when it is disabled, when any of its bytes
// leaves the region of its first byte, when it wraps past the top of the
// address space, or when it reads the register window. Throughput is one
// item per cycle unless both stages are full; each result passes through the
// registered read of the four byte-lane memories of each store, then the
// output register. The two stages form a short pipeline, so an item is still
// taken while a finished result waits at the output, as long as the middle
// stage is free. Flash and RAM contents are undefined after reset; reading a
// byte never written returns whatever the memory holds.
module region_decoded_byte_memory #(
    parameter int unsigned FLASH_BYTES = rdbm_pkg::FLASH_BYTES_DEF,
    parameter int unsigned RAM_BYTES   = rdbm_pkg::RAM_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rdbm_req_if.sink    req,
    rdbm_rsp_if.source  rsp
);
    import rdbm_pkg::*;

    // Each store is split into four byte lanes; lane b holds the bytes with
    // address bits [1:0] == b, so any access touches each lane at most once.
    localparam int unsigned FLASH_ROWS = (FLASH_BYTES + 3) / 4;
    localparam int unsigned RAM_ROWS   = (RAM_BYTES + 3) / 4;
    localparam int unsigned FLASH_RW   = $clog2(FLASH_ROWS);
    localparam int unsigned RAM_RW     = $clog2(RAM_ROWS);
    localparam int unsigned FLASH_AW   = FLASH_RW + 2;
    localparam int unsigned RAM_AW     = RAM_RW + 2;

    localparam logic [ADDR_W:0] FLASH_END  = (ADDR_W + 1)'(FLASH_BYTES);
    localparam logic [ADDR_W:0] RAM_END    = RAM_BASE + (ADDR_W + 1)'(RAM_BYTES);
    localparam logic [ADDR_W:0] PERIPH_END = PERIPH_BASE + PERIPH_LEN;

    // ------------------------------------------------------------------
    // Decode of the item at the input
    // ------------------------------------------------------------------
    logic            accept;
    len_t            len;
    logic [ADDR_W:0] span_start;
    logic [ADDR_W:0] span_end;
    region_t         region;
    logic            permitted;
    logic            wr_go;
    logic            rd_go;
    logic [1:0]      lo2;
    logic [3:0]      lane_en;
    logic [7:0]      lane_wbyte [4];

    assign len        = access_len(req.size);
    assign span_start = {1'b0, req.addr};
    assign span_end   = span_start + {{(ADDR_W - 2){1'b0}}, len};
    assign lo2        = req.addr[1:0];

    // Whole span must lie in one region; the widened end catches wrapping
    always_comb
    begin
        if (span_end <= FLASH_END)
        begin
            region = REGION_FLASH;
        end
        else if (span_start >= RAM_BASE && span_end <= RAM_END)
        begin
            region = REGION_RAM;
        end
        else if (span_start >= PERIPH_BASE && span_end <= PERIPH_END)
        begin
            region = REGION_PERIPH;
        end
        else
        begin
            region = REGION_NONE;
        end
    end

    assign permitted = req.enable && (region != REGION_NONE)
                       && !(region == REGION_PERIPH && req.op == OP_READ);
    assign accept    = req.valid && req.ready;
    assign wr_go     = accept && permitted && (req.op == OP_WRITE);
    assign rd_go     = accept && permitted && (req.op == OP_READ);

    // Lane b carries access byte (b - lo2) mod 4, if that byte is in the access
    always_comb
    begin
        logic [1:0] k;
        for (int b = 0; b < 4; b++)
        begin
            k             = 2'(b) - lo2;
            lane_en[b]    = ({1'b0, k} < len);
            lane_wbyte[b] = 8'(req.write_data >> {k, 3'b000});
        end
    end

    // ------------------------------------------------------------------
    // Byte-lane stores; read data lands in the middle stage
    // ------------------------------------------------------------------
    logic [7:0] flash_q_reg [4];
    logic [7:0] ram_q_reg   [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_lane
        logic [7:0]          flash_mem [FLASH_ROWS];
        logic [7:0]          ram_mem   [RAM_ROWS];
        logic                wraps;
        logic [FLASH_RW-1:0] flash_row;
        logic [RAM_RW-1:0]   ram_row;

        // Lanes below the start lane belong to the following word
        assign wraps     = (2'(b) < lo2);
        assign flash_row = req.addr[FLASH_AW-1:2] + FLASH_RW'(wraps);
        assign ram_row   = req.addr[RAM_AW-1:2] + RAM_RW'(wraps);

        always_ff @(posedge clk)
        begin
            if (wr_go && region == REGION_FLASH && lane_en[b])
            begin
                flash_mem[flash_row] <= lane_wbyte[b];
            end
            if (rd_go && region == REGION_FLASH)
            begin
                flash_q_reg[b] <= flash_mem[flash_row];
            end
        end

        always_ff @(posedge clk)
        begin
            if (wr_go && region == REGION_RAM && lane_en[b])
            begin
                ram_mem[ram_row] <= lane_wbyte[b];
            end
            if (rd_go && region == REGION_RAM)
            begin
                ram_q_reg[b] <= ram_mem[ram_row];
            end
        end
    end

    // ------------------------------------------------------------------
    // Register window: two little-endian words kept as eight bytes
    // ------------------------------------------------------------------
    logic [7:0] periph_reg [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 8; j++)
            begin
                periph_reg[j] <= '0;
            end
        end
        else if (wr_go && region == REGION_PERIPH)
        begin
            for (int j = 0; j < 8; j++)
            begin
                // Span is known to stay inside the window, so no wrap here
                if ({1'b0, 3'(j) - req.addr[2:0]} < {1'b0, len})
                begin
                    periph_reg[j] <= 8'(req.write_data >> {3'(j) - req.addr[2:0], 3'b000});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Middle stage: control that goes with the registered lane data
    // ------------------------------------------------------------------
    logic       a_valid_reg;
    logic       a_valid_next;
    logic [1:0] a_lo2_reg;
    len_t       a_len_reg;
    logic       a_fault_reg;
    logic       a_read_reg;
    logic       a_ram_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       a_move;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign a_move    = a_valid_reg && out_free;
    // Hold off items while reset is applied and while both stages are full and the output is not taken
    assign req.ready = rst_n && (!a_valid_reg || out_free);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_lo2_reg   <= lo2;
            a_len_reg   <= len;
            a_fault_reg <= !permitted;
            a_read_reg  <= permitted && (req.op == OP_READ);
            a_ram_reg   <= (region == REGION_RAM);
        end
    end

    // ------------------------------------------------------------------
    // Assemble the little-endian result and drive the output register
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] assembled;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_fault_reg;

    always_comb
    begin
        logic [1:0] lane;
        logic [7:0] byte_val;
        assembled = '0;
        for (int k = 0; k < 4; k++)
        begin
            lane     = a_lo2_reg + 2'(k);
            byte_val = a_ram_reg ? ram_q_reg[lane] : flash_q_reg[lane];
            // Drop bytes above the access size, and everything for writes and faulted items
            if (a_read_reg && (3'(k) < a_len_reg))
            begin
                assembled[8*k +: 8] = byte_val;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (a_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            out_data_reg  <= assembled;
            out_fault_reg <= a_fault_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.fault     = out_fault_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RDBM_ASSERT_NOW(a_fault_zero, rsp.valid && rsp.fault, rsp.read_data == '0, "fault with data")
    `RDBM_ASSERT_NEXT(a_disabled_faults, accept && !req.enable, a_valid_reg && a_fault_reg, "disabled item not faulted")
    `RDBM_ASSERT_NEXT(a_periph_store, accept && req.enable && req.op == OP_WRITE && req.addr == PERIPH_BASE[ADDR_W-1:0], periph_reg[0] == $past(req.write_data[7:0]), "window byte not stored")
    // Ready is held low during reset, so only a stall out of reset needs full stages
    `RDBM_ASSERT_NOW(a_stall_full, rst_n && !req.ready, a_valid_reg && out_valid_reg, "stall with a free stage")

endmodule

// ===== verif/region_decoded_byte_memory_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for region_decoded_byte_memory: a table of directed accesses,
// then random accesses, each result checked against a byte-level memory predictor or a typed-in result.
// Depends on rdbm_pkg, the rdbm_req_if / rdbm_rsp_if interfaces and the RTL top level.

module region_decoded_byte_memory_tb;
    import rdbm_pkg::*;

    localparam int unsigned FLASH_DEPTH  = FLASH_BYTES_DEF;
    localparam int unsigned RAM_DEPTH    = RAM_BYTES_DEF;
    // The unused size code; the block treats it as a half word
    localparam logic [SIZE_W-1:0] SIZE_SPARE = 2'd3;

    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned MAX_WAIT     = 17;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned REPORT_LIMIT = 10;

    // Marks a table row whose result is typed in rather than predicted
    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    typedef struct packed {
        logic              enable;
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] write_data;
    } access_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              fault;
    } response_t;

    typedef struct packed {
        access_t   acc;
        logic      typed;
        response_t want;
    } access_row_t;

    localparam int unsigned DIRECTED_ROWS = 26;

    // Directed accesses. Every read that is carried out touches only bytes
    // written by an earlier row, since unwritten flash and RAM hold no defined value.
    localparam access_row_t ACCESS_TABLE [DIRECTED_ROWS] = '{
        // disabled accesses: nothing happens, fault raised
        '{'{1'b0, OP_READ,  32'h0000_0000, SIZE_WORD, 32'h0000_0000}, TYPED, '{32'h0, 1'b1}},
        '{'{1'b0, OP_WRITE, 32'h2000_0000, SIZE_WORD, 32'hFFFF_FFFF}, TYPED, '{32'h0, 1'b1}},
        // flash at its base, including an unaligned half word overwrite
        '{'{1'b1, OP_WRITE, 32'h0000_0000, SIZE_WORD, 32'hDEAD_BEEF}, TYPED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_READ,  32'h0000_0000, SIZE_WORD, 32'h0000_0000}, PREDICTED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_WRITE, 32'h0000_0001, SIZE_HALF, 32'h0000_1234}, PREDICTED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_READ,  32'h0000_0003, SIZE_BYTE, 32'h0000_0000}, PREDICTED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_READ,  32'h0000_0000, SIZE_WORD, 32'h0000_0000}, PREDICTED, '{32'h0, 1'b0}},
        // flash top: last word fits, anything straddling the end faults
        '{'{1'b1, OP_WRITE, 32'h0000_FFFC, SIZE_WORD, 32'hFFFF_FFFF}, TYPED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_READ,  32'h0000_FFFC, SIZE_WORD, 32'h0000_0000}, PREDICTED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_WRITE, 32'h0000_FFFD, SIZE_WORD, 32'h1111_1111}, TYPED, '{32'h0, 1'b1}},
        '{'{1'b1, OP_READ,  32'h0000_FFFF, SIZE_HALF, 32'h0000_0000}, TYPED, '{32'h0, 1'b1}},
        '{'{1'b1, OP_READ,  32'h0000_FFFF, SIZE_SPARE, 32'h0000_0000}, TYPED, '{32'h0, 1'b1}},
        // just past flash is unmapped
        '{'{1'b1, OP_WRITE, 32'h0001_0000, SIZE_BYTE, 32'h0000_00AA}, TYPED, '{32'h0, 1'b1}},
        // RAM at both ends
        '{'{1'b1, OP_WRITE, 32'h2000_0000, SIZE_WORD, 32'h0403_0201}, TYPED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_WRITE, 32'h2000_1FFC, SIZE_WORD, 32'h8070_6050}, TYPED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_READ,  32'h2000_0001, SIZE_HALF, 32'h0000_0000}, PREDICTED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_READ,  32'h2000_1FFC, SIZE_WORD, 32'h0000_0000}, PREDICTED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_WRITE, 32'h2000_1FFF, SIZE_HALF, 32'h0000_BEEF}, TYPED, '{32'h0, 1'b1}},
        // just below RAM is unmapped
        '{'{1'b1, OP_READ,  32'h1FFF_FFFF, SIZE_BYTE, 32'h0000_0000}, TYPED, '{32'h0, 1'b1}},
        // register window: writes land, reads and overruns fault
        '{'{1'b1, OP_WRITE, 32'h3000_0000, SIZE_WORD, 32'hCAFE_F00D}, TYPED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_WRITE, 32'h3000_0007, SIZE_BYTE, 32'h0000_005A}, TYPED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_READ,  32'h3000_0004, SIZE_WORD, 32'h0000_0000}, TYPED, '{32'h0, 1'b1}},
        '{'{1'b1, OP_WRITE, 32'h3000_0006, SIZE_WORD, 32'h0000_0000}, TYPED, '{32'h0, 1'b1}},
        // wrap past the top of the address space
        '{'{1'b1, OP_WRITE, 32'hFFFF_FFFE, SIZE_WORD, 32'hFFFF_FFFF}, TYPED, '{32'h0, 1'b1}},
        // spare size code moves two bytes
        '{'{1'b1, OP_WRITE, 32'h2000_0010, SIZE_SPARE, 32'hAABB_CCDD}, TYPED, '{32'h0, 1'b0}},
        '{'{1'b1, OP_READ,  32'h2000_0010, SIZE_SPARE, 32'h0000_0000}, PREDICTED, '{32'h0, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    rdbm_req_if req ();
    rdbm_rsp_if rsp ();

    region_decoded_byte_memory u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Predictor state: byte images of both stores, which bytes hold a defined
    // value, and the two window registers.
    logic [7:0]        flash_image   [FLASH_DEPTH];
    logic [7:0]        ram_image     [RAM_DEPTH];
    bit                flash_written [FLASH_DEPTH];
    bit                ram_written   [RAM_DEPTH];
    logic [DATA_W-1:0] window_regs   [2];

    response_t         expected_responses [$];
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;
    // When set, both sides run without gaps or stalls
    bit                calm = 1'b0;

    function automatic int unsigned span_bytes(input logic [SIZE_W-1:0] size);
        case (size)
            SIZE_BYTE: return 1;
            SIZE_WORD: return 4;
            default:   return 2;
        endcase
    endfunction

    // Region holding every byte of the access, with the offset of its first byte.
    // The span end is worked out one bit wider so that a wrap shows as out of range.
    function automatic region_t decode_span(input logic [ADDR_W-1:0] addr,
                                            input logic [SIZE_W-1:0] size,
                                            output logic [ADDR_W-1:0] offset);
        logic [ADDR_W:0] lo;
        logic [ADDR_W:0] hi;
        lo     = {1'b0, addr};
        hi     = lo + (ADDR_W + 1)'(span_bytes(size));
        offset = '0;
        if (hi <= (ADDR_W + 1)'(FLASH_DEPTH)) begin
            offset = addr;
            return REGION_FLASH;
        end
        if (lo >= RAM_BASE && hi <= RAM_BASE + (ADDR_W + 1)'(RAM_DEPTH)) begin
            offset = addr - RAM_BASE[ADDR_W-1:0];
            return REGION_RAM;
        end
        if (lo >= PERIPH_BASE && hi <= PERIPH_BASE + PERIPH_LEN) begin
            offset = addr - PERIPH_BASE[ADDR_W-1:0];
            return REGION_PERIPH;
        end
        return REGION_NONE;
    endfunction

    // Carry out one accepted access on the predictor state and return its result
    function automatic response_t apply_access(input access_t acc);
        response_t         resp;
        region_t           region;
        logic [ADDR_W-1:0] offset;
        int unsigned       o;
        int unsigned       k;
        resp.read_data = '0;
        resp.fault     = 1'b1;
        if (!acc.enable)
            return resp;
        region = decode_span(acc.addr, acc.size, offset);
        if (region == REGION_NONE || (region == REGION_PERIPH && acc.op == OP_READ))
            return resp;
        for (k = 0; k < span_bytes(acc.size); k++)
        begin
            o = offset + k;
            if (acc.op == OP_WRITE)
            begin
                case (region)
                    REGION_FLASH:
                    begin
                        flash_image[o]   = acc.write_data[8*k +: 8];
                        flash_written[o] = 1'b1;
                    end
                    REGION_RAM:
                    begin
                        ram_image[o]   = acc.write_data[8*k +: 8];
                        ram_written[o] = 1'b1;
                    end
                    default:
                        window_regs[(o / 4) % 2][8*(o % 4) +: 8] = acc.write_data[8*k +: 8];
                endcase
            end
            else if (region == REGION_FLASH)
                resp.read_data[8*k +: 8] = flash_image[o];
            else
                resp.read_data[8*k +: 8] = ram_image[o];
        end
        resp.fault = 1'b0;
        return resp;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
    endtask

    // Watchdog: end the run with an error report once the cycle count reaches its limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("region_decoded_byte_memory_tb: errors");
            $finish;
        end
    end

    // Access side: reset, the directed table, then random items. Each item is
    // predicted at the edge where it is accepted, so the predictor state always
    // matches what the block has seen so far.
    initial
    begin : drive_accesses
        access_t           acc;
        response_t         want;
        region_t           region;
        logic [ADDR_W-1:0] offset;
        int unsigned       gap;
        int unsigned       i;
        int unsigned       k;
        bit                typed;

        window_regs[0]    = '0;
        window_regs[1]    = '0;
        rst_n            <= 1'b0;
        req.valid        <= 1'b0;
        req.enable       <= 1'b0;
        req.op           <= OP_READ;
        req.addr         <= '0;
        req.size         <= SIZE_BYTE;
        req.write_data   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS + RANDOM_ITEMS; i++)
        begin
            // Drain the pipeline once after the table and once mid-way: hold
            // valid low until every expected result has come back.
            if (i == DIRECTED_ROWS || i == DIRECTED_ROWS + RANDOM_ITEMS / 2)
            begin
                req.valid <= 1'b0;
                @(posedge clk);
                while (expected_responses.size() != 0)
                    @(posedge clk);
            end
            // Switch between bursty and calm stretches now and then
            if (i % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);

            if (i < DIRECTED_ROWS)
            begin
                acc   = ACCESS_TABLE[i].acc;
                typed = ACCESS_TABLE[i].typed;
                want  = ACCESS_TABLE[i].want;
            end
            else
            begin
                typed          = PREDICTED;
                acc.enable     = ($urandom_range(0, 19) != 0);
                acc.op         = 1'($urandom_range(0, 1));
                acc.size       = SIZE_W'($urandom_range(0, 3));
                acc.write_data = $urandom;
                // Most items go to small windows at region edges, so that
                // written bytes get read back and the boundaries get crossed.
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4:
                        acc.addr = $urandom_range(0, 127);
                    5, 6:
                        acc.addr = FLASH_DEPTH - 64 + $urandom_range(0, 67);
                    7, 8, 9, 10, 11:
                        acc.addr = RAM_BASE[ADDR_W-1:0] - 4 + $urandom_range(0, 131);
                    12, 13:
                        acc.addr = RAM_BASE[ADDR_W-1:0] + RAM_DEPTH - 64
                                   + $urandom_range(0, 67);
                    14, 15:
                        acc.addr = PERIPH_BASE[ADDR_W-1:0] - 4 + $urandom_range(0, 15);
                    16:
                        acc.addr = $urandom;
                    17:
                        acc.addr = 32'hFFFF_FFF0 + $urandom_range(0, 15);
                    18:
                        acc.addr = $urandom_range(0, FLASH_DEPTH - 1);
                    default:
                        acc.addr = RAM_BASE[ADDR_W-1:0] + $urandom_range(0, RAM_DEPTH - 1);
                endcase
                // Turn a read of any never-written byte into a write of it
                if (acc.enable && acc.op == OP_READ)
                begin
                    region = decode_span(acc.addr, acc.size, offset);
                    if (region == REGION_FLASH || region == REGION_RAM)
                        for (k = 0; k < span_bytes(acc.size); k++)
                            if (region == REGION_FLASH ? !flash_written[offset + k]
                                                       : !ram_written[offset + k])
                                acc.op = OP_WRITE;
                end
            end

            gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (gap != 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            req.valid      <= 1'b1;
            req.enable     <= acc.enable;
            req.op         <= acc.op;
            req.addr       <= acc.addr;
            req.size       <= acc.size;
            req.write_data <= acc.write_data;
            @(posedge clk);
            while (req.ready !== 1'b1)
                @(posedge clk);

            // Accepted at this edge: advance the predictor, keep its answer
            // unless the table gives the result outright
            if (typed)
                void'(apply_access(acc));
            else
                want = apply_access(acc);
            expected_responses.push_back(want);
        end
        req.valid <= 1'b0;

        while (expected_responses.size() != 0)
            @(posedge clk);
        // Allow for the pipeline depth so that a stray result still shows up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_responses.size() == 0)
            $display("region_decoded_byte_memory_tb: clean");
        else
            $display("region_decoded_byte_memory_tb: errors");
        $finish;
    end

    // Result side: stall at random, then take the next result and compare it,
    // field by field, with the oldest expectation.
    initial
    begin : take_responses
        response_t   want;
        int unsigned stall;

        rsp.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);

        forever
        begin
            stall = calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (rsp.valid !== 1'b1)
                @(posedge clk);

            if (expected_responses.size() == 0)
                report_mismatch("unexpected result", '0, rsp.read_data);
            else
            begin
                want = expected_responses.pop_front();
                if (rsp.read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, rsp.read_data);
                if (rsp.fault !== want.fault)
                    report_mismatch("fault", DATA_W'(want.fault), DATA_W'(rsp.fault));
            end
        end
    end

endmodule

// ===== region_decoded_byte_memory.f =====
+incdir+sv
sv/rdbm_pkg.sv
sv/rdbm_if.sv
sv/region_decoded_byte_memory.sv
verif/region_decoded_byte_memory_tb.sv
